@@ src/mcv_pkg.sv @@
package mcv_pkg;

  // Input commands
  localparam logic [1:0] CMD_MIDI   = 2'd0;
  localparam logic [1:0] CMD_TICK   = 2'd1;
  localparam logic [1:0] CMD_REPEAT = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_LISTEN_CHANNEL = 2'd0;
  localparam logic [1:0] CFG_PLAY_MODE      = 2'd1;
  localparam logic [1:0] CFG_BYTE_TIMEOUT   = 2'd2;

  // Play modes
  localparam logic [1:0] MODE_IGNORE = 2'd0;
  localparam logic [1:0] MODE_DIRECT = 2'd1;
  localparam logic [1:0] MODE_ARP    = 2'd2;

  // MIDI status nibbles
  localparam logic [3:0] MIDI_NOTE_OFF = 4'h8;
  localparam logic [3:0] MIDI_NOTE_ON  = 4'h9;

  localparam logic [7:0] NOTE_LOW  = 8'd36;
  localparam logic [7:0] TABLE_LEN = 8'd60;
  localparam logic [7:0] NO_NOTE   = 8'hFF;

  localparam logic [3:0]  LISTEN_CHANNEL_RST = 4'd0;
  localparam logic [1:0]  PLAY_MODE_RST      = MODE_DIRECT;
  localparam logic [7:0]  BYTE_TIMEOUT_RST   = 8'd10;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_NOTE = 2'd1,
    PH_VEL  = 2'd2
  } phase_t;

  // Chromatic CV table, index 0 is note 36
  function automatic logic [11:0] cv_rom(input logic [5:0] idx);
    logic [11:0] v;
    unique case (idx)
      6'd0:  v = 12'd136;  6'd1:  v = 12'd144;  6'd2:  v = 12'd152;  6'd3:  v = 12'd161;
      6'd4:  v = 12'd171;  6'd5:  v = 12'd181;  6'd6:  v = 12'd192;  6'd7:  v = 12'd203;
      6'd8:  v = 12'd215;  6'd9:  v = 12'd228;  6'd10: v = 12'd242;  6'd11: v = 12'd256;
      6'd12: v = 12'd271;  6'd13: v = 12'd287;  6'd14: v = 12'd304;  6'd15: v = 12'd322;
      6'd16: v = 12'd342;  6'd17: v = 12'd362;  6'd18: v = 12'd383;  6'd19: v = 12'd406;
      6'd20: v = 12'd430;  6'd21: v = 12'd456;  6'd22: v = 12'd483;  6'd23: v = 12'd512;
      6'd24: v = 12'd542;  6'd25: v = 12'd575;  6'd26: v = 12'd609;  6'd27: v = 12'd645;
      6'd28: v = 12'd683;  6'd29: v = 12'd724;  6'd30: v = 12'd767;  6'd31: v = 12'd813;
      6'd32: v = 12'd861;  6'd33: v = 12'd912;  6'd34: v = 12'd966;  6'd35: v = 12'd1024;
      6'd36: v = 12'd1085; 6'd37: v = 12'd1149; 6'd38: v = 12'd1217; 6'd39: v = 12'd1290;
      6'd40: v = 12'd1367; 6'd41: v = 12'd1448; 6'd42: v = 12'd1534; 6'd43: v = 12'd1625;
      6'd44: v = 12'd1722; 6'd45: v = 12'd1824; 6'd46: v = 12'd1933; 6'd47: v = 12'd2048;
      6'd48: v = 12'd2169; 6'd49: v = 12'd2298; 6'd50: v = 12'd2435; 6'd51: v = 12'd2580;
      6'd52: v = 12'd2733; 6'd53: v = 12'd2896; 6'd54: v = 12'd3068; 6'd55: v = 12'd3250;
      6'd56: v = 12'd3443; 6'd57: v = 12'd3648; 6'd58: v = 12'd3865; 6'd59: v = 12'd4095;
      default: v = 12'd0;
    endcase
    return v;
  endfunction

endpackage

@@ src/midi_note_to_cv_with_key_table.sv @@
// Flow: a tick or a non-final byte is taken in ST_IDLE; a repeat request or note-on result goes through
// ST_EMIT to the output register; a note-off goes ST_SCAN (one key memory read per slot, pipelined), ST_GATE,
// then ST_EMIT. in_ready is high only in ST_IDLE, so a new request waits until the last result is loaded into
// the output register, and ST_EMIT waits for out_ready to free it; ticks and non-final bytes stay in ST_IDLE.
// Reset (rst_n low, synchronous): parser idle, all slots free, CV/velocity/gate zero,
// registers back to channel 0, direct mode, timeout 10. Key notes need no clearing.
module midi_note_to_cv_with_key_table
  import mcv_pkg::*;
#(
  parameter int KEY_SLOTS = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_result_kind,
  output logic        out_cv_loaded,
  output logic [11:0] out_cv_value,
  output logic [7:0]  out_velocity,
  output logic        out_gate,
  output logic        out_slots_full,
  output logic [7:0]  out_repeat_note,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [7:0]  cfg_wdata
);

  localparam int SLOT_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(KEY_SLOTS - 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,  // takes requests
    ST_SCAN = 2'd1,  // note-off: walk key memory for the note
    ST_GATE = 2'd2,  // note-off: gate check on the updated slot flags
    ST_EMIT = 2'd3   // load the result register once it is free
  } state_t;

  // configuration
  logic [3:0] listen_channel_r;
  logic [1:0] play_mode_r;
  logic [7:0] byte_timeout_r;

  // parser and voice state
  state_t      state_r;
  phase_t      phase_r;
  logic [3:0]  msg_channel_r;
  logic [3:0]  msg_command_r;
  logic [7:0]  msg_note_r;
  logic [7:0]  timeout_r;
  logic [KEY_SLOTS-1:0] used_r;
  logic [SLOT_W-1:0]    repeat_idx_r;
  logic        gate_r;
  logic [11:0] cv_r;
  logic [7:0]  vel_r;

  // pending result flags
  logic        kind_r;
  logic        loaded_r;
  logic        full_r;
  logic        rep_found_r;

  // note-off scan pipeline
  logic [SLOT_W-1:0] scan_r;
  logic              scan_done_r;
  logic              chk_vld_r;
  logic [SLOT_W-1:0] chk_idx_r;

  // key note memory: one write and one registered read port
  logic [7:0]        key_mem [KEY_SLOTS];
  logic              mem_we;
  logic [SLOT_W-1:0] mem_waddr;
  logic              mem_re;
  logic [SLOT_W-1:0] mem_raddr;
  logic [7:0]        rd_data_r;

  // output register
  logic        out_valid_r;
  logic        out_kind_r;
  logic        out_loaded_r;
  logic [11:0] out_cv_r;
  logic [7:0]  out_vel_r;
  logic        out_gate_r;
  logic        out_full_r;
  logic [7:0]  out_note_r;

  logic        accept;
  logic        midi_on;
  logic        byte_take;
  logic        msg_done;
  logic        chan_hit;
  logic        is_note_on;
  logic        is_note_off;
  logic [7:0]  note_off_low;
  logic        in_table;
  logic [7:0]  timeout_dec;

  logic              free_any;
  logic [SLOT_W-1:0] free_idx;
  logic              rep_any;
  logic [SLOT_W-1:0] rep_idx;
  logic              chk_hit;
  logic              out_free;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  assign midi_on   = (play_mode_r == MODE_DIRECT) || (play_mode_r == MODE_ARP);
  assign byte_take = accept && (in_cmd == CMD_MIDI) && midi_on;
  assign msg_done  = byte_take && (phase_r == PH_VEL);

  assign chan_hit     = (msg_channel_r == listen_channel_r);
  assign is_note_on   = chan_hit && (msg_command_r == MIDI_NOTE_ON) && (msg_note_r >= NOTE_LOW);
  assign is_note_off  = chan_hit && (msg_command_r == MIDI_NOTE_OFF);
  assign note_off_low = msg_note_r - NOTE_LOW;
  assign in_table     = (note_off_low < TABLE_LEN) && (play_mode_r == MODE_DIRECT);

  assign timeout_dec = (timeout_r != 8'd0) ? (timeout_r - 8'd1) : 8'd0;

  // first free slot
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = KEY_SLOTS - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_any = 1'b1;
        free_idx = SLOT_W'(i);
      end
    end
  end

  // round-robin pick: first used slot at or after the repeat pointer, else first used slot
  always_comb begin
    logic              hi_any;
    logic [SLOT_W-1:0] hi_idx;
    logic              lo_any;
    logic [SLOT_W-1:0] lo_idx;
    hi_any = 1'b0;
    hi_idx = '0;
    lo_any = 1'b0;
    lo_idx = '0;
    for (int i = KEY_SLOTS - 1; i >= 0; i--) begin
      if (used_r[i]) begin
        lo_any = 1'b1;
        lo_idx = SLOT_W'(i);
        if (SLOT_W'(i) >= repeat_idx_r) begin
          hi_any = 1'b1;
          hi_idx = SLOT_W'(i);
        end
      end
    end
    rep_any = lo_any;
    rep_idx = hi_any ? hi_idx : lo_idx;
  end

  // memory port control; the FSM never reads and writes the same slot in one cycle
  assign mem_we    = msg_done && is_note_on && free_any;
  assign mem_waddr = free_idx;
  assign mem_re    = (accept && (in_cmd == CMD_REPEAT) && rep_any) ||
                     ((state_r == ST_SCAN) && !scan_done_r);
  assign mem_raddr = (state_r == ST_SCAN) ? scan_r : rep_idx;

  assign chk_hit = chk_vld_r && used_r[chk_idx_r] && (rd_data_r == msg_note_r);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      key_mem[mem_waddr] <= msg_note_r;
    end
    if (mem_re) begin
      rd_data_r <= key_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      listen_channel_r <= LISTEN_CHANNEL_RST;
      play_mode_r      <= PLAY_MODE_RST;
      byte_timeout_r   <= BYTE_TIMEOUT_RST;
      state_r          <= ST_IDLE;
      phase_r          <= PH_IDLE;
      msg_channel_r    <= '0;
      msg_command_r    <= '0;
      msg_note_r       <= '0;
      timeout_r        <= '0;
      used_r           <= '0;
      repeat_idx_r     <= '0;
      gate_r           <= 1'b0;
      cv_r             <= '0;
      vel_r            <= '0;
      kind_r           <= 1'b0;
      loaded_r         <= 1'b0;
      full_r           <= 1'b0;
      rep_found_r      <= 1'b0;
      scan_r           <= '0;
      scan_done_r      <= 1'b0;
      chk_vld_r        <= 1'b0;
      chk_idx_r        <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      // configuration must be written only while idle; the block itself does not enforce this
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_LISTEN_CHANNEL: listen_channel_r <= cfg_wdata[3:0];
          CFG_PLAY_MODE:      play_mode_r      <= cfg_wdata[1:0];
          CFG_BYTE_TIMEOUT:   byte_timeout_r   <= cfg_wdata;
          default: ;
        endcase
      end

      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            unique case (in_cmd)
              CMD_TICK: begin
                timeout_r <= timeout_dec;
                if (timeout_dec == 8'd0) begin
                  phase_r <= PH_IDLE;
                end
              end
              CMD_REPEAT: begin
                kind_r      <= 1'b1;
                loaded_r    <= 1'b0;
                full_r      <= 1'b0;
                rep_found_r <= rep_any;
                if (rep_any && (rep_idx != LAST_SLOT)) begin
                  repeat_idx_r <= rep_idx + 1'b1;
                end else begin
                  repeat_idx_r <= '0;
                end
                state_r <= ST_EMIT;
              end
              CMD_MIDI: begin
                if (midi_on) begin
                  timeout_r <= byte_timeout_r;
                  unique case (phase_r)
                    PH_NOTE: begin
                      msg_note_r <= in_data_byte;
                      phase_r    <= PH_VEL;
                    end
                    PH_VEL: begin
                      // message complete
                      phase_r     <= PH_IDLE;
                      kind_r      <= 1'b0;
                      rep_found_r <= 1'b0;
                      loaded_r    <= 1'b0;
                      full_r      <= 1'b0;
                      state_r     <= ST_EMIT;
                      if (is_note_on) begin
                        if (in_table) begin
                          vel_r    <= in_data_byte;
                          cv_r     <= cv_rom(note_off_low[5:0]);
                          gate_r   <= 1'b1;
                          loaded_r <= 1'b1;
                        end
                        if (free_any) begin
                          used_r[free_idx] <= 1'b1;
                        end else begin
                          full_r <= 1'b1;
                        end
                      end else if (is_note_off) begin
                        scan_r      <= '0;
                        scan_done_r <= 1'b0;
                        state_r     <= ST_SCAN;
                      end
                    end
                    default: begin
                      // any byte in idle is taken as status
                      msg_channel_r <= in_data_byte[3:0];
                      msg_command_r <= in_data_byte[7:4];
                      phase_r       <= PH_NOTE;
                    end
                  endcase
                end
              end
              default: ;
            endcase
          end
        end

        ST_SCAN: begin
          // read slot scan_r while checking the slot read last cycle
          chk_vld_r <= mem_re;
          chk_idx_r <= scan_r;
          if (mem_re) begin
            if (scan_r == LAST_SLOT) begin
              scan_done_r <= 1'b1;
            end else begin
              scan_r <= scan_r + 1'b1;
            end
          end
          if (chk_hit) begin
            used_r[chk_idx_r] <= 1'b0;
            chk_vld_r         <= 1'b0;
            state_r           <= ST_GATE;
          end else if (chk_vld_r && (chk_idx_r == LAST_SLOT)) begin
            chk_vld_r <= 1'b0;
            state_r   <= ST_GATE;
          end
        end

        ST_GATE: begin
          if ((used_r == '0) && (play_mode_r == MODE_DIRECT)) begin
            gate_r <= 1'b0;
          end
          state_r <= ST_EMIT;
        end

        ST_EMIT: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_kind_r   <= kind_r;
            out_loaded_r <= loaded_r;
            out_cv_r     <= cv_r;
            out_vel_r    <= vel_r;
            out_gate_r   <= gate_r;
            out_full_r   <= full_r;
            out_note_r   <= rep_found_r ? rd_data_r : NO_NOTE;
            state_r      <= ST_IDLE;
          end
        end

        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = out_kind_r;
  assign out_cv_loaded   = out_loaded_r;
  assign out_cv_value    = out_cv_r;
  assign out_velocity    = out_vel_r;
  assign out_gate        = out_gate_r;
  assign out_slots_full  = out_full_r;
  assign out_repeat_note = out_note_r;

endmodule
